FILE: rtl/assert_macros.svh
// Assertion macros shared by the form-urlencoded parser RTL.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define FUP_ASSERT(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("assertion failed");
`define FUP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define FUP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FUP_ASSERT(label, expr)
`define FUP_ASSERT_IMPL(label, ante, cons)
`define FUP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: rtl/fup_pkg.sv
// Package for the form-urlencoded parser: constants, result types and hex decode.
// Used by fup_engine and form_urlencoded_parser_unit; depends on nothing.
package fup_pkg;

    localparam int VALUE_LIMIT_MAX = 4096;
    localparam int LEN_W           = 13;
    localparam int MAX_RES         = 4;
    localparam int CNT_W           = 3;

    localparam logic [LEN_W-1:0] MAX_VALUE_LEN_RESET = 13'd256;
    localparam logic             REG_MAX_VALUE_LEN   = 1'b0;

    localparam logic [7:0] CHAR_PCT   = 8'h25;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_AMP   = 8'h26;
    localparam logic [7:0] CHAR_EQ    = 8'h3D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [4:0] NOT_HEX    = 5'd16;

    typedef enum logic [1:0] {
        ST_KEPT      = 2'd0,
        ST_NO_EQ     = 2'd1,
        ST_EMPTY_KEY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ESC_NONE = 2'd0,
        ESC_PCT  = 2'd1,
        ESC_HEX  = 2'd2
    } t_esc;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       in_value;
        logic       pair_end;
        t_status    status;
        logic       trunc;
        logic       last;
    } t_result;

    typedef struct packed {
        t_result [MAX_RES-1:0] res;
        logic [CNT_W-1:0]      count;
    } t_batch;

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        v = NOT_HEX;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = 5'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = 5'(c - 8'h61 + 8'd10);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = 5'(c - 8'h41 + 8'd10);
        end
        return v;
    endfunction

endpackage

FILE: rtl/fup_engine.sv
// Parser state and combinational decode of one body byte into a batch of results.
// Depends on fup_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fup_engine (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_step,
    input  logic [7:0]               i_data_byte,
    input  logic                     i_last_byte,
    input  logic [fup_pkg::LEN_W-1:0] i_limit,
    output fup_pkg::t_batch          o_batch
);
    import fup_pkg::*;

    logic             r_value_phase;
    t_esc             r_esc;
    logic [7:0]       r_held;
    logic             r_kne;
    logic [LEN_W-1:0] r_len;
    logic             r_cut;

    logic             n_value_phase;
    t_esc             n_esc;
    logic [7:0]       n_held;
    logic             n_kne;
    logic [LEN_W-1:0] n_len;
    logic             n_cut;

    logic [4:0]       h;
    logic [4:0]       hi;
    logic             is_hex;
    logic             c_en;
    logic [7:0]       c_byte;
    t_esc             esc_new;
    logic [7:0]       held_new;
    logic             phase_mid;
    logic             sep;
    logic             close_now;
    logic [4:0]       cand_en;
    logic [7:0]       cand [5];
    logic [7:0]       data [MAX_RES];
    logic [CNT_W-1:0] n_data;
    logic [LEN_W-1:0] room;
    logic [CNT_W-1:0] keep;
    logic             kne_mid;
    logic             cut_mid;
    logic [LEN_W-1:0] len_mid;
    t_status          close_status;
    t_batch           batch;

    always_comb begin
        h         = hex_val(i_data_byte);
        hi        = hex_val(r_held);
        is_hex    = !h[4];
        c_en      = 1'b0;
        c_byte    = i_data_byte;
        esc_new   = ESC_NONE;
        held_new  = r_held;
        phase_mid = r_value_phase;
        sep       = 1'b0;

        if (r_esc == ESC_PCT && is_hex) begin
            esc_new  = ESC_HEX;
            held_new = i_data_byte;
        end else if (r_esc == ESC_HEX && is_hex) begin
            c_en   = 1'b1;
            c_byte = {hi[3:0], h[3:0]};
        end else if (i_data_byte == CHAR_AMP) begin
            sep = 1'b1;
        end else if (i_data_byte == CHAR_EQ && !r_value_phase) begin
            phase_mid = 1'b1;
        end else if (i_data_byte == CHAR_PLUS) begin
            c_en   = 1'b1;
            c_byte = CHAR_SPACE;
        end else if (i_data_byte == CHAR_PCT) begin
            esc_new = ESC_PCT;
        end else begin
            c_en = 1'b1;
        end

        close_now = sep || i_last_byte;

        cand_en[0] = (r_esc != ESC_NONE) && !is_hex;
        cand_en[1] = (r_esc == ESC_HEX) && !is_hex;
        cand_en[2] = c_en;
        cand_en[3] = i_last_byte && !sep && (esc_new != ESC_NONE);
        cand_en[4] = i_last_byte && !sep && (esc_new == ESC_HEX);
        cand[0]    = CHAR_PCT;
        cand[1]    = r_held;
        cand[2]    = c_byte;
        cand[3]    = CHAR_PCT;
        cand[4]    = held_new;

        for (int j = 0; j < MAX_RES; j++) begin
            data[j] = 8'h00;
        end
        n_data = '0;
        for (int i = 0; i < 5; i++) begin
            if (cand_en[i]) begin
                data[n_data[1:0]] = cand[i];
                n_data            = n_data + 1'b1;
            end
        end

        room = (r_len < i_limit) ? (i_limit - r_len) : '0;
        if (r_value_phase && (room < LEN_W'(n_data))) begin
            keep = room[CNT_W-1:0];
        end else begin
            keep = n_data;
        end
        kne_mid = r_kne | (!r_value_phase && (n_data != '0));
        cut_mid = r_cut | (r_value_phase && (keep != n_data));
        len_mid = r_value_phase ? (r_len + LEN_W'(keep)) : r_len;

        if (!phase_mid) begin
            close_status = ST_NO_EQ;
        end else if (!kne_mid) begin
            close_status = ST_EMPTY_KEY;
        end else begin
            close_status = ST_KEPT;
        end

        for (int j = 0; j < MAX_RES; j++) begin
            batch.res[j].out_byte = data[j];
            batch.res[j].in_value = r_value_phase;
            batch.res[j].pair_end = 1'b0;
            batch.res[j].status   = ST_KEPT;
            batch.res[j].trunc    = 1'b0;
            batch.res[j].last     = 1'b0;
        end
        if (close_now) begin
            batch.res[keep[1:0]].out_byte = 8'h00;
            batch.res[keep[1:0]].in_value = 1'b0;
            batch.res[keep[1:0]].pair_end = 1'b1;
            batch.res[keep[1:0]].status   = close_status;
            batch.res[keep[1:0]].trunc    = cut_mid;
        end
        batch.count = keep + CNT_W'(close_now);
        if (batch.count != '0) begin
            batch.res[2'(batch.count - 1'b1)].last = 1'b1;
        end

        if (close_now) begin
            n_value_phase = 1'b0;
            n_esc         = ESC_NONE;
            n_held        = 8'h00;
            n_kne         = 1'b0;
            n_len         = '0;
            n_cut         = 1'b0;
        end else begin
            n_value_phase = phase_mid;
            n_esc         = esc_new;
            n_held        = held_new;
            n_kne         = kne_mid;
            n_len         = len_mid;
            n_cut         = cut_mid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value_phase <= 1'b0;
            r_esc         <= ESC_NONE;
            r_held        <= 8'h00;
            r_kne         <= 1'b0;
            r_len         <= '0;
            r_cut         <= 1'b0;
        end else if (i_step) begin
            r_value_phase <= n_value_phase;
            r_esc         <= n_esc;
            r_held        <= n_held;
            r_kne         <= n_kne;
            r_len         <= n_len;
            r_cut         <= n_cut;
        end
    end

    assign o_batch = batch;

    `FUP_ASSERT(a_count_range, batch.count <= CNT_W'(MAX_RES))
    `FUP_ASSERT_IMPL(a_full_batch_closes, batch.count == CNT_W'(MAX_RES), batch.res[3].pair_end)
    `FUP_ASSERT_NEXT(a_close_clears, i_step && close_now, r_len == '0 && !r_value_phase)

endmodule

FILE: rtl/form_urlencoded_parser_unit.sv
// Top level of the streaming form-urlencoded parser: input register, APB register
// and result batch buffer. Depends on fup_pkg, fup_engine and assert_macros.svh.
//
// One body byte is taken per item on the input channel and decoded combinationally
// from the input register into a batch of zero to four results, which the output
// side hands out one per cycle while i_out_ready is high. A byte that gives at most
// one result then sustains one item per cycle; a byte that gives more holds the next
// byte back until its last result is handed out. The max_value_len register sits at
// byte address 0; the user must write it only while idle, as the block does not
// enforce this. Values above 4096 act as 4096.
`include "assert_macros.svh"

module form_urlencoded_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_in_value,
    output logic        o_pair_end,
    output logic [1:0]  o_pair_status,
    output logic        o_value_truncated,
    output logic        o_last_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fup_pkg::*;

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  r_in_last;
    logic [LEN_W-1:0]      r_max_value_len;
    t_result [MAX_RES-1:0] r_buf;
    logic [CNT_W-1:0]      r_rem;
    logic [1:0]            r_idx;

    logic                  in_fire;
    logic                  out_fire;
    logic                  load;
    logic [LEN_W-1:0]      limit;
    t_batch                batch;
    t_result               cur;

    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_MAX_VALUE_LEN) ? {19'b0, r_max_value_len} : 32'b0;
    assign limit    = (r_max_value_len > LEN_W'(VALUE_LIMIT_MAX)) ?
                      LEN_W'(VALUE_LIMIT_MAX) : r_max_value_len;

    assign o_out_valid = (r_rem != '0);
    assign out_fire    = o_out_valid && i_out_ready;
    assign load        = r_in_valid && ((r_rem == '0) || ((r_rem == CNT_W'(1)) && out_fire));
    assign o_in_ready  = !r_in_valid || load;
    assign in_fire     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_value_len <= MAX_VALUE_LEN_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_MAX_VALUE_LEN)) begin
            r_max_value_len <= pwdata[LEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_byte <= 8'h00;
            r_in_last <= 1'b0;
        end else if (in_fire) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    fup_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (load),
        .i_data_byte (r_in_byte),
        .i_last_byte (r_in_last),
        .i_limit     (limit),
        .o_batch     (batch)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
            r_idx <= '0;
        end else if (load) begin
            r_rem <= batch.count;
            r_idx <= '0;
        end else if (out_fire) begin
            r_rem <= r_rem - 1'b1;
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_buf <= batch.res;
        end
    end

    assign cur               = r_buf[r_idx];
    assign o_out_byte        = cur.out_byte;
    assign o_in_value        = cur.in_value;
    assign o_pair_end        = cur.pair_end;
    assign o_pair_status     = cur.status;
    assign o_value_truncated = cur.trunc;
    assign o_last_result     = cur.last;

    `FUP_ASSERT_IMPL(a_final_entry_marked, o_out_valid && r_rem == CNT_W'(1), o_last_result)
    `FUP_ASSERT_NEXT(a_drain_empties, out_fire && o_last_result && !load, !o_out_valid)
    `FUP_ASSERT_IMPL(a_pair_end_no_byte, o_out_valid && o_pair_end, o_out_byte == 8'h00 && !o_in_value)

endmodule
